>>> sv/ppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types, register indexes, status codes and fixed-point constants for
// the pinhole projection with lens distortion.
// ----------------------------------------------------------------------------
package ppd_pkg;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic sat;
        logic zneg;
    } t_flags;

    localparam logic [2:0] REG_FOCAL_X       = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y       = 3'd1;
    localparam logic [2:0] REG_CENTER_X      = 3'd2;
    localparam logic [2:0] REG_CENTER_Y      = 3'd3;
    localparam logic [2:0] REG_RADIAL_K1     = 3'd4;
    localparam logic [2:0] REG_RADIAL_K2     = 3'd5;
    localparam logic [2:0] REG_TANGENTIAL_P1 = 3'd6;
    localparam logic [2:0] REG_TANGENTIAL_P2 = 3'd7;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DEPTH = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    localparam logic signed [31:0] RADIAL_K3 = 32'sd0;
    localparam logic signed [31:0] DIST_MIN  = 32'sd27;
    localparam logic [31:0]        FOCAL_RST = 32'd65536;

    localparam logic [63:0]        CD_ONE    = 64'h0000_0000_1000_0000;
    localparam logic signed [63:0] S32_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN   = -64'sh0000_0000_8000_0000;

    localparam int DIV_LAT = 35;
    localparam int MUL_LAT = 4;

endpackage

>>> sv/ppd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_div
// Pipelined restoring divider: x/z and y/z in Q4.28, truncated toward zero,
// clamped to the signed 32-bit range. One quotient bit per stage.
// ----------------------------------------------------------------------------
module ppd_div (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [31:0]  i_px,
    input  logic signed [31:0]  i_py,
    input  logic signed [31:0]  i_pz,
    output logic signed [31:0]  o_x,
    output logic signed [31:0]  o_y,
    output ppd_pkg::t_flags     o_flags
);

    logic [31:0] w_ax;
    logic [31:0] w_ay;

    logic [63:0] r_nx;
    logic [63:0] r_ny;
    logic [30:0] r_da;
    logic        r_sxa;
    logic        r_sya;
    logic        r_znega;

    logic [63:0] r_remx [0:32];
    logic [63:0] r_remy [0:32];
    logic [31:0] r_qx   [0:32];
    logic [31:0] r_qy   [0:32];
    logic [30:0] r_d    [0:32];
    logic        r_sx   [0:32];
    logic        r_sy   [0:32];
    logic        r_ovx  [0:32];
    logic        r_ovy  [0:32];
    logic        r_zneg [0:32];

    assign w_ax = i_px[31] ? 32'(-i_px) : 32'(i_px);
    assign w_ay = i_py[31] ? 32'(-i_py) : 32'(i_py);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx    <= {32'd0, w_ax} << 28;
            r_ny    <= {32'd0, w_ay} << 28;
            r_da    <= i_pz[30:0];
            r_sxa   <= i_px[31];
            r_sya   <= i_py[31];
            r_znega <= i_pz[31] | (i_pz == 32'sd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_remx[0] <= r_nx;
            r_remy[0] <= r_ny;
            r_qx[0]   <= 32'd0;
            r_qy[0]   <= 32'd0;
            r_d[0]    <= r_da;
            r_sx[0]   <= r_sxa;
            r_sy[0]   <= r_sya;
            r_ovx[0]  <= r_nx >= {1'b0, r_da, 32'd0};
            r_ovy[0]  <= r_ny >= {1'b0, r_da, 32'd0};
            r_zneg[0] <= r_znega;
        end
    end

    for (genvar k = 1; k <= 32; k++) begin : g_step
        logic [63:0] w_subd;
        logic        w_gex;
        logic        w_gey;

        assign w_subd = {33'd0, r_d[k-1]} << (32 - k);
        assign w_gex  = r_remx[k-1] >= w_subd;
        assign w_gey  = r_remy[k-1] >= w_subd;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_remx[k] <= w_gex ? r_remx[k-1] - w_subd : r_remx[k-1];
                r_remy[k] <= w_gey ? r_remy[k-1] - w_subd : r_remy[k-1];
                r_qx[k]   <= {r_qx[k-1][30:0], w_gex};
                r_qy[k]   <= {r_qy[k-1][30:0], w_gey};
                r_d[k]    <= r_d[k-1];
                r_sx[k]   <= r_sx[k-1];
                r_sy[k]   <= r_sy[k-1];
                r_ovx[k]  <= r_ovx[k-1];
                r_ovy[k]  <= r_ovy[k-1];
                r_zneg[k] <= r_zneg[k-1];
            end
        end
    end

    logic signed [31:0] n_x;
    logic signed [31:0] n_y;
    logic               n_satx;
    logic               n_saty;

    always_comb begin
        n_satx = 1'b0;
        n_saty = 1'b0;
        if (!r_sx[32]) begin
            if (r_ovx[32] || r_qx[32] > 32'h7FFF_FFFF) begin
                n_x    = 32'sh7FFF_FFFF;
                n_satx = 1'b1;
            end else begin
                n_x = $signed(r_qx[32]);
            end
        end else begin
            if (r_ovx[32] || r_qx[32] > 32'h8000_0000) begin
                n_x    = $signed(32'h8000_0000);
                n_satx = 1'b1;
            end else begin
                n_x = $signed(32'(-r_qx[32]));
            end
        end
        if (!r_sy[32]) begin
            if (r_ovy[32] || r_qy[32] > 32'h7FFF_FFFF) begin
                n_y    = 32'sh7FFF_FFFF;
                n_saty = 1'b1;
            end else begin
                n_y = $signed(r_qy[32]);
            end
        end else begin
            if (r_ovy[32] || r_qy[32] > 32'h8000_0000) begin
                n_y    = $signed(32'h8000_0000);
                n_saty = 1'b1;
            end else begin
                n_y = $signed(32'(-r_qy[32]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x          <= n_x;
            o_y          <= n_y;
            o_flags.sat  <= n_satx | n_saty;
            o_flags.zneg <= r_zneg[32];
        end
    end

endmodule

>>> sv/ppd_mulq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_mulq
// Pipelined signed 64x64 Q.28 multiply: four partial products of the halves,
// sum, then shift right by 28 with the magnitude truncated.
// ----------------------------------------------------------------------------
module ppd_mulq (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [63:0] o_p
);

    localparam logic [127:0] TRUNC_BIAS = 128'h0FFF_FFFF;

    logic [63:0]        r_pll;
    logic signed [64:0] r_plh;
    logic signed [64:0] r_phl;
    logic signed [63:0] r_phh;

    logic [63:0]        r_pll2;
    logic signed [65:0] r_mid;
    logic signed [63:0] r_phh2;

    logic [127:0]       r_full;
    logic [127:0]       w_adj;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pll <= i_a[31:0] * i_b[31:0];
            r_plh <= $signed({1'b0, i_a[31:0]}) * $signed(i_b[63:32]);
            r_phl <= $signed(i_a[63:32]) * $signed({1'b0, i_b[31:0]});
            r_phh <= $signed(i_a[63:32]) * $signed(i_b[63:32]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pll2 <= r_pll;
            r_mid  <= r_plh + r_phl;
            r_phh2 <= r_phh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_full <= {r_phh2, 64'd0} + {{30{r_mid[65]}}, r_mid, 32'd0} + {64'd0, r_pll2};
        end
    end

    assign w_adj = r_full + (r_full[127] ? TRUNC_BIAS : 128'd0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= $signed(w_adj[91:28]);
        end
    end

endmodule

>>> sv/pinhole_project_with_distortion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_project_with_distortion
// Projects camera-frame points to pixel coordinates through a pinhole model
// with radial (k1, k2, k3) and tangential (p1, p2) lens distortion.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_stall   i_in  (ppd_pkg::t_in)
//   output   out        o_valid / i_stall   o_out (ppd_pkg::t_out)
//   config   in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One point per cycle while the output is not stalled; a point passes the
// bit-per-stage divider, six chained multiplier stages, four add/clamp stages.
// Reset is synchronous, active low; it clears valid bits and loads the
// registers with their defaults. When the output holds a transaction that is
// stalled, the whole pipeline freezes and the input is stalled.
// ----------------------------------------------------------------------------
module pinhole_project_with_distortion (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ppd_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output ppd_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    localparam int ML      = ppd_pkg::MUL_LAT;
    localparam int LAT     = ppd_pkg::DIV_LAT + 6 * ML + 4;
    localparam int XL_LEN  = 5 * ML + 2;
    localparam int AL_LEN  = 3 * ML + 1;
    localparam int FL_LEN  = 6 * ML + 3;
    localparam int K1_LEN  = 2 * ML;

    logic [31:0]        r_focal_x;
    logic [31:0]        r_focal_y;
    logic [31:0]        r_center_x;
    logic [31:0]        r_center_y;
    logic signed [31:0] r_k1;
    logic signed [31:0] r_k2;
    logic signed [31:0] r_p1;
    logic signed [31:0] r_p2;

    logic               w_en;
    logic [LAT-1:0]     r_vld;

    logic signed [31:0] w_x;
    logic signed [31:0] w_y;
    ppd_pkg::t_flags    w_flags;

    logic signed [31:0] r_xl [0:XL_LEN-1];
    logic signed [31:0] r_yl [0:XL_LEN-1];
    ppd_pkg::t_flags    r_fl [0:FL_LEN-1];

    logic signed [63:0] w_x64;
    logic signed [63:0] w_y64;
    logic signed [63:0] w_xx;
    logic signed [63:0] w_yy;
    logic signed [63:0] w_xy;

    logic signed [63:0] r_r2;
    logic signed [63:0] r_a1;
    logic signed [63:0] r_a2;
    logic signed [63:0] r_a3;
    logic signed [63:0] r_r2l [0:ML-1];
    logic signed [63:0] r_a1l [0:AL_LEN-1];
    logic signed [63:0] r_a2l [0:AL_LEN-1];
    logic signed [63:0] r_a3l [0:AL_LEN-1];

    logic signed [63:0] w_r4;
    logic signed [63:0] w_k1r2;
    logic signed [63:0] w_r6;
    logic signed [63:0] w_k2r4;
    logic signed [63:0] w_k3r6;
    logic signed [63:0] r_k1l [0:K1_LEN-1];
    logic signed [63:0] r_k2l [0:ML-1];
    logic signed [63:0] r_cd;

    logic signed [63:0] w_xcd;
    logic signed [63:0] w_ycd;
    logic signed [63:0] w_p1a1;
    logic signed [63:0] w_p2a2;
    logic signed [63:0] w_p1a3;
    logic signed [63:0] w_p2a1;
    logic               w_dist;
    logic signed [63:0] n_xd;
    logic signed [63:0] n_yd;
    logic signed [63:0] r_xd;
    logic signed [63:0] r_yd;

    logic signed [63:0] w_pu;
    logic signed [63:0] w_pv;
    logic signed [63:0] w_u;
    logic signed [63:0] w_v;
    ppd_pkg::t_out      n_out;
    ppd_pkg::t_flags    w_fl_end;

    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= ppd_pkg::FOCAL_RST;
            r_focal_y  <= ppd_pkg::FOCAL_RST;
            r_center_x <= 32'd0;
            r_center_y <= 32'd0;
            r_k1       <= 32'sd0;
            r_k2       <= 32'sd0;
            r_p1       <= 32'sd0;
            r_p2       <= 32'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppd_pkg::REG_FOCAL_X:       r_focal_x  <= i_cfg_data;
                ppd_pkg::REG_FOCAL_Y:       r_focal_y  <= i_cfg_data;
                ppd_pkg::REG_CENTER_X:      r_center_x <= i_cfg_data;
                ppd_pkg::REG_CENTER_Y:      r_center_y <= i_cfg_data;
                ppd_pkg::REG_RADIAL_K1:     r_k1       <= $signed(i_cfg_data);
                ppd_pkg::REG_RADIAL_K2:     r_k2       <= $signed(i_cfg_data);
                ppd_pkg::REG_TANGENTIAL_P1: r_p1       <= $signed(i_cfg_data);
                ppd_pkg::REG_TANGENTIAL_P2: r_p2       <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    ppd_div u_div (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_px    (i_in.point_x),
        .i_py    (i_in.point_y),
        .i_pz    (i_in.point_z),
        .o_x     (w_x),
        .o_y     (w_y),
        .o_flags (w_flags)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xl[0] <= w_x;
            r_yl[0] <= w_y;
            r_fl[0] <= w_flags;
            for (int i = 1; i < XL_LEN; i++) begin
                r_xl[i] <= r_xl[i-1];
                r_yl[i] <= r_yl[i-1];
            end
            for (int i = 1; i < FL_LEN; i++) begin
                r_fl[i] <= r_fl[i-1];
            end
        end
    end

    assign w_x64 = {{32{w_x[31]}}, w_x};
    assign w_y64 = {{32{w_y[31]}}, w_y};

    ppd_mulq u_mul_xx (.i_clk(i_clk), .i_en(w_en), .i_a(w_x64), .i_b(w_x64), .o_p(w_xx));
    ppd_mulq u_mul_yy (.i_clk(i_clk), .i_en(w_en), .i_a(w_y64), .i_b(w_y64), .o_p(w_yy));
    ppd_mulq u_mul_xy (.i_clk(i_clk), .i_en(w_en), .i_a(w_x64), .i_b(w_y64), .o_p(w_xy));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2 <= w_xx + w_yy;
            r_a1 <= w_xy + w_xy;
            r_a2 <= w_xx + w_yy + w_xx + w_xx;
            r_a3 <= w_xx + w_yy + w_yy + w_yy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2l[0] <= r_r2;
            r_k1l[0] <= w_k1r2;
            r_k2l[0] <= w_k2r4;
            for (int i = 1; i < ML; i++) begin
                r_r2l[i] <= r_r2l[i-1];
                r_k2l[i] <= r_k2l[i-1];
            end
            for (int i = 1; i < K1_LEN; i++) begin
                r_k1l[i] <= r_k1l[i-1];
            end
            r_a1l[0] <= r_a1;
            r_a2l[0] <= r_a2;
            r_a3l[0] <= r_a3;
            for (int i = 1; i < AL_LEN; i++) begin
                r_a1l[i] <= r_a1l[i-1];
                r_a2l[i] <= r_a2l[i-1];
                r_a3l[i] <= r_a3l[i-1];
            end
        end
    end

    ppd_mulq u_mul_r4 (.i_clk(i_clk), .i_en(w_en), .i_a(r_r2), .i_b(r_r2), .o_p(w_r4));
    ppd_mulq u_mul_k1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ({{32{r_k1[31]}}, r_k1}),
        .i_b   (r_r2),
        .o_p   (w_k1r2)
    );
    ppd_mulq u_mul_r6 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_r4),
        .i_b   (r_r2l[ML-1]),
        .o_p   (w_r6)
    );
    ppd_mulq u_mul_k2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ({{32{r_k2[31]}}, r_k2}),
        .i_b   (w_r4),
        .o_p   (w_k2r4)
    );
    ppd_mulq u_mul_k3 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ({{32{ppd_pkg::RADIAL_K3[31]}}, ppd_pkg::RADIAL_K3}),
        .i_b   (w_r6),
        .o_p   (w_k3r6)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cd <= $signed(ppd_pkg::CD_ONE) + r_k1l[K1_LEN-1] + r_k2l[ML-1] + w_k3r6;
        end
    end

    ppd_mulq u_mul_xcd (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ({{32{r_xl[4*ML+1][31]}}, r_xl[4*ML+1]}),
        .i_b   (r_cd),
        .o_p   (w_xcd)
    );
    ppd_mulq u_mul_ycd (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ({{32{r_yl[4*ML+1][31]}}, r_yl[4*ML+1]}),
        .i_b   (r_cd),
        .o_p   (w_ycd)
    );
    ppd_mulq u_mul_p1a1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ({{32{r_p1[31]}}, r_p1}),
        .i_b   (r_a1l[AL_LEN-1]),
        .o_p   (w_p1a1)
    );
    ppd_mulq u_mul_p2a2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ({{32{r_p2[31]}}, r_p2}),
        .i_b   (r_a2l[AL_LEN-1]),
        .o_p   (w_p2a2)
    );
    ppd_mulq u_mul_p1a3 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ({{32{r_p1[31]}}, r_p1}),
        .i_b   (r_a3l[AL_LEN-1]),
        .o_p   (w_p1a3)
    );
    ppd_mulq u_mul_p2a1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ({{32{r_p2[31]}}, r_p2}),
        .i_b   (r_a1l[AL_LEN-1]),
        .o_p   (w_p2a1)
    );

    assign w_dist = (r_k1 > ppd_pkg::DIST_MIN) || (r_k1 < -ppd_pkg::DIST_MIN);

    always_comb begin
        if (w_dist) begin
            n_xd = w_xcd + w_p1a1 + w_p2a2;
            n_yd = w_ycd + w_p1a3 + w_p2a1;
        end else begin
            n_xd = {{32{r_xl[XL_LEN-1][31]}}, r_xl[XL_LEN-1]};
            n_yd = {{32{r_yl[XL_LEN-1][31]}}, r_yl[XL_LEN-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xd <= n_xd;
            r_yd <= n_yd;
        end
    end

    ppd_mulq u_mul_fx (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_xd),
        .i_b   ({32'd0, r_focal_x}),
        .o_p   (w_pu)
    );
    ppd_mulq u_mul_fy (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_yd),
        .i_b   ({32'd0, r_focal_y}),
        .o_p   (w_pv)
    );

    assign w_u      = w_pu + $signed({32'd0, r_center_x});
    assign w_v      = w_pv + $signed({32'd0, r_center_y});
    assign w_fl_end = r_fl[FL_LEN-1];

    always_comb begin
        logic sat;
        sat = w_fl_end.sat;
        if (w_u > ppd_pkg::S32_MAX) begin
            n_out.pixel_u = 32'sh7FFF_FFFF;
            sat           = 1'b1;
        end else if (w_u < ppd_pkg::S32_MIN) begin
            n_out.pixel_u = $signed(32'h8000_0000);
            sat           = 1'b1;
        end else begin
            n_out.pixel_u = w_u[31:0];
        end
        if (w_v > ppd_pkg::S32_MAX) begin
            n_out.pixel_v = 32'sh7FFF_FFFF;
            sat           = 1'b1;
        end else if (w_v < ppd_pkg::S32_MIN) begin
            n_out.pixel_v = $signed(32'h8000_0000);
            sat           = 1'b1;
        end else begin
            n_out.pixel_v = w_v[31:0];
        end
        n_out.status = sat ? ppd_pkg::STATUS_SAT : ppd_pkg::STATUS_OK;
        if (w_fl_end.zneg) begin
            n_out.pixel_u = 32'sd0;
            n_out.pixel_v = 32'sd0;
            n_out.status  = ppd_pkg::STATUS_DEPTH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out <= n_out;
        end
    end

endmodule
